### rtl/tpj_pkg.sv
package tpj_pkg;

  // one second in nanoseconds, and the same value shifted up by 16 for the Q16 rate
  localparam int unsigned           NS_W       = 30;
  localparam logic [NS_W-1:0]       NS_PER_SEC = 30'd1000000000;
  localparam int unsigned           DVD_W      = NS_W + 16;
  localparam logic [DVD_W-1:0]      DVD_CONST  = {NS_PER_SEC, 16'd0};

  // divide iteration counts: rate divide over the full dividend, period divide over 1e9
  localparam int unsigned           RATE_ITER  = DVD_W;
  localparam int unsigned           PER_ITER   = NS_W;
  localparam int unsigned           CNT_IT_W   = $clog2(RATE_ITER);

  // field widths
  localparam int unsigned           TS_W       = 64;
  localparam int unsigned           SUB_W      = TS_W + 1;
  localparam int unsigned           CNT_W      = 32;
  localparam int unsigned           OUT_W      = 32;
  localparam int unsigned           RATE_W     = 30;
  localparam int unsigned           M_DATA_W   = 232;

  // period after reset: 1e9 / 60
  localparam logic [NS_W-1:0]       RESET_PERIOD = 30'd16666666;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PER_DIV,
    ST_DIFF,
    ST_DUE_CMP,
    ST_JIT_A,
    ST_JIT_B,
    ST_MISS,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef enum logic {
    OP_CHECK = 1'b0,
    OP_MARK  = 1'b1
  } op_t;

endpackage

### rtl/tpj_sub.sv
module tpj_sub (
  input  logic [tpj_pkg::SUB_W-1:0] a,
  input  logic [tpj_pkg::SUB_W-1:0] b,
  output logic [tpj_pkg::SUB_W-1:0] diff,
  output logic                      borrow
);

  logic [tpj_pkg::SUB_W:0] full;

  // shared subtractor: borrow set when a < b
  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[tpj_pkg::SUB_W-1:0];
  assign borrow = full[tpj_pkg::SUB_W];

endmodule

### rtl/tick_pacer_jitter_monitor_unit.sv
// tick pacer and jitter monitor, one 65-bit subtractor shared by every arithmetic and divide step
// check: straight to the done step (no tick yet or zero period), else difference and due-compare steps
// mark: a first mark goes straight to the done step, else 3 or 4 arithmetic steps + 46 divide steps,
// the divide skipped when the delta is zero; the done step holds while the result register is full
// one beat at a time; s_tready is high only while the sequencer is idle
// config write: computes the period by 30 divide steps, no beat taken meanwhile
// rst (sync, active high): period 16666666 (rate 60), counters, times, delta, jitter, rate_q16 cleared
module tick_pacer_jitter_monitor_unit (
  input  logic                            clk,
  input  logic                            rst,
  // config channel: target_rate_hz
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tpj_pkg::RATE_W-1:0]      cfg_data,
  // input beats
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [tpj_pkg::TS_W-1:0]        s_tdata,   // [63:0] timestamp_ns
  input  logic [0:0]                      s_tuser,   // [0] operation
  // result beats
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [0] tick_due, [64:1] last_delta_ns, [128:65] jitter, [160:129] missed_count,
  // [192:161] total_count, [224:193] rate_q16, [231:225] zero
  output logic [tpj_pkg::M_DATA_W-1:0]    m_tdata
);

  tpj_pkg::state_t state, state_next;

  logic [tpj_pkg::NS_W-1:0]     period;
  logic [tpj_pkg::TS_W-1:0]     last_tick;
  logic [tpj_pkg::TS_W-1:0]     delta;
  logic [tpj_pkg::TS_W-1:0]     jitter;
  logic [tpj_pkg::CNT_W-1:0]    missed;
  logic [tpj_pkg::CNT_W-1:0]    total;
  logic [tpj_pkg::OUT_W-1:0]    rate_q;
  logic                         due;

  // per-beat working registers
  logic                         op;
  logic [tpj_pkg::TS_W-1:0]     now;
  logic [tpj_pkg::TS_W-1:0]     dif;
  logic [tpj_pkg::TS_W-1:0]     dvs;
  logic [tpj_pkg::TS_W-1:0]     rem;
  logic [tpj_pkg::DVD_W-1:0]    dvd;
  logic [tpj_pkg::OUT_W-1:0]    quo;
  logic [tpj_pkg::CNT_IT_W-1:0] cnt;

  logic [tpj_pkg::SUB_W-1:0]    sub_a, sub_b, sub_diff;
  logic                         sub_borrow;

  logic                         in_beat, cfg_beat, out_load;

  assign cfg_ready = (state == tpj_pkg::ST_IDLE);
  assign s_tready  = (state == tpj_pkg::ST_IDLE) && !cfg_valid;
  assign in_beat   = s_tvalid && s_tready;
  assign cfg_beat  = cfg_valid && cfg_ready;
  assign out_load  = (state == tpj_pkg::ST_DONE) && (!m_tvalid || m_tready);

  // operand select for the shared subtractor
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    case (state)
      tpj_pkg::ST_DIFF: begin
        sub_a = {1'b0, now};
        sub_b = {1'b0, last_tick};
      end
      tpj_pkg::ST_DUE_CMP, tpj_pkg::ST_JIT_A: begin
        sub_a = {1'b0, dif};
        sub_b = tpj_pkg::SUB_W'(period);
      end
      tpj_pkg::ST_JIT_B: begin
        sub_a = tpj_pkg::SUB_W'(period);
        sub_b = {1'b0, dif};
      end
      tpj_pkg::ST_MISS: begin
        sub_a = tpj_pkg::SUB_W'({period, 1'b0});
        sub_b = {1'b0, dif};
      end
      tpj_pkg::ST_DIV, tpj_pkg::ST_PER_DIV: begin
        sub_a = {rem, dvd[tpj_pkg::DVD_W-1]};
        sub_b = {1'b0, dvs};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  tpj_sub u_sub (
    .a      (sub_a),
    .b      (sub_b),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpj_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      tpj_pkg::ST_IDLE: begin
        if (cfg_beat) begin
          state_next = tpj_pkg::ST_PER_DIV;
        end else if (in_beat) begin
          if (s_tuser[0] == tpj_pkg::OP_MARK) begin
            state_next = (last_tick != '0) ? tpj_pkg::ST_DIFF : tpj_pkg::ST_DONE;
          end else if (period == '0 || last_tick == '0) begin
            state_next = tpj_pkg::ST_DONE;
          end else begin
            state_next = tpj_pkg::ST_DIFF;
          end
        end
      end
      tpj_pkg::ST_PER_DIV: begin
        if (cnt == '0) state_next = tpj_pkg::ST_IDLE;
      end
      tpj_pkg::ST_DIFF: begin
        state_next = (op == tpj_pkg::OP_MARK) ? tpj_pkg::ST_JIT_A : tpj_pkg::ST_DUE_CMP;
      end
      tpj_pkg::ST_DUE_CMP: begin
        state_next = tpj_pkg::ST_DONE;
      end
      tpj_pkg::ST_JIT_A: begin
        state_next = sub_borrow ? tpj_pkg::ST_JIT_B : tpj_pkg::ST_MISS;
      end
      tpj_pkg::ST_JIT_B: begin
        state_next = tpj_pkg::ST_MISS;
      end
      tpj_pkg::ST_MISS: begin
        state_next = (dif == '0) ? tpj_pkg::ST_DONE : tpj_pkg::ST_DIV;
      end
      tpj_pkg::ST_DIV: begin
        if (cnt == '0) state_next = tpj_pkg::ST_DONE;
      end
      tpj_pkg::ST_DONE: begin
        if (out_load) state_next = tpj_pkg::ST_IDLE;
      end
      default: begin
        state_next = tpj_pkg::ST_IDLE;
      end
    endcase
  end

  // monitor state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      period    <= tpj_pkg::RESET_PERIOD;
      last_tick <= '0;
      delta     <= '0;
      jitter    <= '0;
      missed    <= '0;
      total     <= '0;
      rate_q    <= '0;
    end else begin
      case (state)
        tpj_pkg::ST_IDLE: begin
          if (cfg_beat) begin
            last_tick <= '0;
            delta     <= '0;
            jitter    <= '0;
            missed    <= '0;
            total     <= '0;
            rate_q    <= '0;
            dvs       <= (cfg_data == '0) ? tpj_pkg::TS_W'(1) : tpj_pkg::TS_W'(cfg_data);
            rem       <= '0;
            dvd       <= tpj_pkg::DVD_CONST;
            cnt       <= tpj_pkg::CNT_IT_W'(tpj_pkg::PER_ITER - 1);
          end else if (in_beat) begin
            op  <= s_tuser[0];
            now <= s_tdata;
            due <= (period != '0) && (last_tick == '0) && (s_tuser[0] == tpj_pkg::OP_CHECK);
            if (s_tuser[0] == tpj_pkg::OP_MARK) begin
              total <= total + 1'b1;
              if (last_tick == '0) last_tick <= s_tdata;
            end
          end
        end
        tpj_pkg::ST_DIFF: begin
          dif <= sub_diff[tpj_pkg::TS_W-1:0];
          if (op == tpj_pkg::OP_MARK) begin
            delta     <= sub_diff[tpj_pkg::TS_W-1:0];
            last_tick <= now;
          end
        end
        tpj_pkg::ST_DUE_CMP: begin
          due <= !sub_borrow;
        end
        tpj_pkg::ST_JIT_A: begin
          jitter <= sub_diff[tpj_pkg::TS_W-1:0];
        end
        tpj_pkg::ST_JIT_B: begin
          jitter <= sub_diff[tpj_pkg::TS_W-1:0];
        end
        tpj_pkg::ST_MISS: begin
          // delta above twice the period
          if (sub_borrow && period != '0) missed <= missed + 1'b1;
          if (dif == '0) rate_q <= '0;
          dvs <= dif;
          rem <= '0;
          dvd <= tpj_pkg::DVD_CONST;
          cnt <= tpj_pkg::CNT_IT_W'(tpj_pkg::RATE_ITER - 1);
        end
        tpj_pkg::ST_DIV, tpj_pkg::ST_PER_DIV: begin
          // one restoring divide step per cycle
          rem <= sub_borrow ? sub_a[tpj_pkg::TS_W-1:0] : sub_diff[tpj_pkg::TS_W-1:0];
          quo <= {quo[tpj_pkg::OUT_W-2:0], !sub_borrow};
          dvd <= {dvd[tpj_pkg::DVD_W-2:0], 1'b0};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            if (state == tpj_pkg::ST_DIV) begin
              rate_q <= {quo[tpj_pkg::OUT_W-2:0], !sub_borrow};
            end else begin
              period <= {quo[tpj_pkg::NS_W-2:0], !sub_borrow};
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'd0, rate_q, tpj_pkg::OUT_W'(total), tpj_pkg::OUT_W'(missed),
                  jitter, delta, due};
    end
  end

  // no beat taken right after one is accepted
  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !s_tready)
    else $error("input taken while a beat is in progress");

  // a config write blocks input during the period divide
  a_cfg_block: assert property (@(posedge clk) disable iff (rst)
    cfg_beat |=> (state == tpj_pkg::ST_PER_DIV) && !s_tready)
    else $error("config write did not start the period divide");

  // the divider never runs on a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == tpj_pkg::ST_DIV || state == tpj_pkg::ST_PER_DIV) |-> (dvs != '0))
    else $error("divide started with zero divisor");

  // a result is loaded only from the done step
  a_load_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == tpj_pkg::ST_DONE))
    else $error("result raised outside the done step");

endmodule

### sim/tick_pacer_jitter_monitor_unit_tb.sv
`timescale 1ns / 100ps

module tick_pacer_jitter_monitor_unit_tb;

  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned RUN_ITEMS   = 150;
  localparam int unsigned SETTLE      = 64;
  localparam int unsigned HOLD_LEN    = 600;
  localparam int unsigned HOLD_AFTER  = 300;
  localparam logic [63:0] Q16_SECOND  = 64'd1000000000 << 16;

  // one result beat, highest field first
  typedef struct packed {
    logic [6:0]  pad;
    logic [31:0] rate;
    logic [31:0] total;
    logic [31:0] missed;
    logic [63:0] jitter;
    logic [63:0] delta;
    logic        due;
  } tick_status_t;

  typedef struct {
    tpj_pkg::op_t op;
    logic [63:0]  ts;
  } pacer_beat_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [tpj_pkg::RATE_W-1:0]    cfg_data = '0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [tpj_pkg::TS_W-1:0]      s_tdata = '0;
  logic [0:0]                    s_tuser = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [tpj_pkg::M_DATA_W-1:0]  m_tdata;

  // pacer state as the testbench sees it
  logic [63:0] mon_period;
  logic [63:0] mon_last_tick;
  logic [63:0] mon_delta;
  logic [63:0] mon_jitter;
  logic [31:0] mon_missed;
  logic [31:0] mon_total;

  pacer_beat_t  beat_q[$];
  tick_status_t status_q[$];
  pacer_beat_t  next_beat;

  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned results_seen;
  int unsigned idle_cycles;
  int          errors = 0;
  bit          no_idle = 1'b0;

  tick_pacer_jitter_monitor_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #5 clk = ~clk;

  // rate write: derive the period and clear everything else
  function automatic void load_target_rate(logic [tpj_pkg::RATE_W-1:0] rate);
    logic [63:0] r;
    r = 64'(rate);
    if (r == 0) r = 64'd1;
    mon_period    = 64'd1000000000 / r;
    mon_last_tick = '0;
    mon_delta     = '0;
    mon_jitter    = '0;
    mon_missed    = '0;
    mon_total     = '0;
  endfunction

  // status after one check or mark
  function automatic tick_status_t advance_monitor(tpj_pkg::op_t op, logic [63:0] ts);
    tick_status_t s;
    logic [63:0]  d;
    logic [63:0]  q;
    s = '0;
    if (op == tpj_pkg::OP_CHECK) begin
      if (mon_period == 0) s.due = 1'b0;
      else if (mon_last_tick == 0) s.due = 1'b1;
      else s.due = ((ts - mon_last_tick) >= mon_period);
    end else begin
      if (mon_last_tick != 0) begin
        d          = ts - mon_last_tick;
        mon_delta  = d;
        mon_jitter = (d > mon_period) ? d - mon_period : mon_period - d;
        if (mon_period != 0 && d > 2 * mon_period) mon_missed = mon_missed + 1;
      end
      mon_last_tick = ts;
      mon_total     = mon_total + 1;
    end
    s.delta  = mon_delta;
    s.jitter = mon_jitter;
    s.missed = mon_missed;
    s.total  = mon_total;
    if (mon_delta != 0) begin
      q      = Q16_SECOND / mon_delta;
      s.rate = q[31:0];
    end
    return s;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 6);
    if (r < 98) return $urandom_range(7, 80);
    return $urandom_range(100, 300);
  endfunction

  function automatic int unsigned pick_stall();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 60);
    return $urandom_range(100, 200);
  endfunction

  // mark spacing around one period
  function automatic logic [63:0] nominal_step(int unsigned p);
    if (p == 0) return 64'($urandom_range(0, 5000));
    return 64'(p - p / 4 + $urandom_range(0, p / 2));
  endfunction

  // check offset close to one period, both sides of it
  function automatic logic [63:0] near_period(int unsigned p);
    if (p < 8) return 64'($urandom_range(0, 2 * p + 2));
    return 64'(p - p / 8 + $urandom_range(0, p / 4));
  endfunction

  task automatic queue_beat(tpj_pkg::op_t op, logic [63:0] ts);
    pacer_beat_t b;
    b.op = op;
    b.ts = ts;
    beat_q.push_back(b);
  endtask

  task automatic flag_mismatch(string field, logic [63:0] want, logic [63:0] got_v);
    errors++;
    if (errors <= 10)
      $display("mismatch on %s: expected %h, got %h", field, want, got_v);
  endtask

  task automatic check_result(logic [tpj_pkg::M_DATA_W-1:0] data);
    tick_status_t got;
    tick_status_t want;
    got = data;
    if (status_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("result beat with nothing expected: %h", data);
    end else begin
      want = status_q.pop_front();
      if (got.due    !== want.due)    flag_mismatch("tick_due", 64'(want.due), 64'(got.due));
      if (got.delta  !== want.delta)  flag_mismatch("last_delta_ns", want.delta, got.delta);
      if (got.jitter !== want.jitter) flag_mismatch("jitter", want.jitter, got.jitter);
      if (got.missed !== want.missed)
        flag_mismatch("missed_count", 64'(want.missed), 64'(got.missed));
      if (got.total  !== want.total)
        flag_mismatch("total_count", 64'(want.total), 64'(got.total));
      if (got.rate   !== want.rate)   flag_mismatch("rate_q16", 64'(want.rate), 64'(got.rate));
      if (got.pad    !== 7'd0)        flag_mismatch("padding", 64'd0, 64'(got.pad));
    end
  endtask

  task automatic write_target_rate(logic [tpj_pkg::RATE_W-1:0] rate);
    @(posedge clk);
    cfg_data  <= rate;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    load_target_rate(rate);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_until_drained();
    @(posedge clk);
    while (beat_q.size() != 0 || s_tvalid || status_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // mostly well-paced marks and checks, some missed ticks and wild times
  task automatic queue_random_run(int n);
    logic [63:0] cur;
    int unsigned p;
    int unsigned r;
    p   = mon_period[31:0];
    cur = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'($urandom);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        cur = cur + nominal_step(p);
        queue_beat(tpj_pkg::OP_MARK, cur);
      end else if (r < 85) begin
        queue_beat(tpj_pkg::OP_CHECK, cur + near_period(p));
      end else if (r < 91) begin
        cur = cur + 2 * 64'(p) + 64'($urandom_range(0, 3));
        queue_beat(tpj_pkg::OP_MARK, cur);
      end else if (r < 96) begin
        cur = {$urandom, $urandom};
        queue_beat(tpj_pkg::OP_MARK, cur);
      end else begin
        queue_beat(tpj_pkg::OP_CHECK, {$urandom, $urandom});
      end
    end
  endtask

  // sender: one beat at a time from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (s_tvalid && s_tready)
        status_q.push_back(advance_monitor(tpj_pkg::op_t'(s_tuser[0]), s_tdata));
      if (s_tvalid && !s_tready) begin
        // hold the beat until taken
      end else if (gap_left != 0) begin
        s_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (beat_q.size() != 0) begin
        next_beat = beat_q.pop_front();
        s_tvalid  <= 1'b1;
        s_tdata   <= next_beat.ts;
        s_tuser   <= next_beat.op;
        gap_left  <= pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: compare each result beat, stall at random
  always @(posedge clk) begin
    if (rst) begin
      m_tready     <= 1'b0;
      stall_left   <= 0;
      results_seen <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_result(m_tdata);
        results_seen <= results_seen + 1;
      end
      if (stall_left != 0) begin
        m_tready   <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        m_tready <= (hold_left == 0);
        if (!no_idle && $urandom_range(0, 3) == 0) stall_left <= pick_stall();
      end
    end
  end

  // one long hold-off on the result side so the input backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0]                t;
    logic [63:0]                p;
    logic [tpj_pkg::RATE_W-1:0] rate_plan[8];

    load_target_rate(30'd60);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed beats at the reset rate
    p = mon_period;
    queue_beat(tpj_pkg::OP_CHECK, 64'd5);            // no tick yet
    queue_beat(tpj_pkg::OP_MARK, 64'd0);             // mark at time zero keeps "no tick"
    queue_beat(tpj_pkg::OP_CHECK, 64'd123);
    t = 64'd1000;
    queue_beat(tpj_pkg::OP_MARK, t);                 // first mark
    queue_beat(tpj_pkg::OP_CHECK, t + p - 1);        // just short of due
    queue_beat(tpj_pkg::OP_CHECK, t + p);            // exactly due
    t = t + p;
    queue_beat(tpj_pkg::OP_MARK, t);                 // delta equals period, no jitter
    t = t + 2 * p;
    queue_beat(tpj_pkg::OP_MARK, t);                 // twice the period, not missed
    t = t + 2 * p + 1;
    queue_beat(tpj_pkg::OP_MARK, t);                 // just over twice, missed
    t = t + 1;
    queue_beat(tpj_pkg::OP_MARK, t);                 // delta one, rate truncated
    queue_beat(tpj_pkg::OP_CHECK, t - 5);            // time going backwards on check
    queue_beat(tpj_pkg::OP_MARK, t - 1000);          // backwards mark, wrapped delta
    queue_beat(tpj_pkg::OP_MARK, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_beat(tpj_pkg::OP_CHECK, 64'd0);            // wraps to a difference of one
    queue_beat(tpj_pkg::OP_MARK, 64'd0);             // back to "no tick"
    queue_beat(tpj_pkg::OP_CHECK, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_beat(tpj_pkg::OP_MARK, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_beat(tpj_pkg::OP_MARK, 64'h5555_5555_5555_5555);
    queue_beat(tpj_pkg::OP_CHECK, 64'h5555_5555_5555_5555 + p);
    wait_until_drained();

    // rate settings: 1000, zero, one, exactly one billion, above it, all ones, random
    rate_plan[0] = 30'd1000;
    rate_plan[1] = 30'd0;
    rate_plan[2] = 30'h3FFF_FFFF;
    rate_plan[3] = 30'd1000000000;
    rate_plan[4] = 30'd1000000001;
    rate_plan[5] = tpj_pkg::RATE_W'($urandom_range(2, 100000));
    rate_plan[6] = 30'd1;
    rate_plan[7] = tpj_pkg::RATE_W'($urandom);

    foreach (rate_plan[k]) begin
      no_idle = (k == 3 || k == 6);
      write_target_rate(rate_plan[k]);
      queue_random_run(RUN_ITEMS);
      wait_until_drained();
    end
    no_idle = 1'b0;

    repeat (100) @(posedge clk);
    if (status_q.size() != 0) begin
      errors++;
      $display("%0d results never arrived", status_q.size());
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
